FILE: hw/rtl/kiss_frame_deframer_macros.svh
// Assertion macros shared by the deframer checker.
// No dependencies; include by bare file name.
`ifndef KISS_FRAME_DEFRAMER_MACROS_SVH
`define KISS_FRAME_DEFRAMER_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define KFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked on every rising clk edge, reset included.
`define KFD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/kfd_pkg.sv
// Shared types and constants of the KISS frame deframer.
// No dependencies; imported by the decoder and the top level.
package kfd_pkg;

	localparam logic [7:0] KISS_FEND  = 8'hC0;
	localparam logic [7:0] KISS_FESC  = 8'hDB;
	localparam logic [7:0] KISS_TFEND = 8'hDC;
	localparam logic [7:0] KISS_TFESC = 8'hDD;
	localparam logic [3:0] PORT_MASK  = 4'hF;

	localparam int unsigned MIN_LEN_W   = 12;
	localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 12'd20;
	localparam int unsigned INDEX_W     = 11;
	localparam int unsigned LENGTH_W    = 12;

	typedef enum logic [1:0] {
		CMD_UNSEEN  = 2'd0,
		CMD_PAYLOAD = 2'd1,
		CMD_OTHER   = 2'd2
	} cmd_status_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_END,
		ACT_OPEN,
		ACT_CMD,
		ACT_ESC,
		ACT_BYTE
	} act_t;

	typedef struct packed {
		logic                kind;
		logic [7:0]          data_byte;
		logic [INDEX_W-1:0]  byte_index;
		logic [LENGTH_W-1:0] frame_length;
		logic                frame_ok;
	} result_t;

endpackage

FILE: hw/rtl/kfd_decode.sv
// Per-byte KISS decoder: frame, command, escape and count state.
// Depends on kfd_pkg.
module kfd_decode #(
	parameter int unsigned MAX_PAYLOAD_BYTES = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic [7:0]                        byte_in,
	input  logic [kfd_pkg::MIN_LEN_W-1:0]     min_len,
	output logic                              res_valid,
	output kfd_pkg::result_t                  res
);
	import kfd_pkg::*;

	localparam int unsigned CW = $clog2(MAX_PAYLOAD_BYTES + 1);
	localparam int unsigned XW = (CW > MIN_LEN_W) ? CW : MIN_LEN_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD_BYTES);

	logic          framing_q, framing_n;
	logic          esc_q, esc_n;
	cmd_status_t   cmd_q, cmd_n;
	logic [CW-1:0] count_q, count_n;
	act_t          act;
	logic [7:0]    dec_byte;
	logic [XW-1:0] count_x;

	assign count_x = XW'(count_q);

	// Classify the byte against the current state.
	always_comb begin
		priority if (framing_q && byte_in == KISS_FEND && cmd_q == CMD_PAYLOAD) begin
			act = ACT_END;
		end else if (byte_in == KISS_FEND) begin
			act = ACT_OPEN;
		end else if (!framing_q || count_q >= MAX_CNT) begin
			act = ACT_NONE;
		end else if (count_q == '0 && cmd_q == CMD_UNSEEN) begin
			act = ACT_CMD;
		end else if (cmd_q != CMD_PAYLOAD) begin
			act = ACT_NONE;
		end else if (byte_in == KISS_FESC) begin
			act = ACT_ESC;
		end else begin
			act = ACT_BYTE;
		end
	end

	always_comb begin
		dec_byte = byte_in;
		if (esc_q) begin
			if (byte_in == KISS_TFEND) begin
				dec_byte = KISS_FEND;
			end else if (byte_in == KISS_TFESC) begin
				dec_byte = KISS_FESC;
			end
		end
	end

	// Next state.
	always_comb begin
		framing_n = framing_q;
		esc_n     = esc_q;
		cmd_n     = cmd_q;
		count_n   = count_q;
		unique case (act)
			ACT_END: begin
				framing_n = 1'b0;
			end
			ACT_OPEN: begin
				framing_n = 1'b1;
				cmd_n     = CMD_UNSEEN;
				count_n   = '0;
			end
			ACT_CMD: begin
				cmd_n = ((byte_in[3:0] & PORT_MASK) == 4'h0) ? CMD_PAYLOAD : CMD_OTHER;
			end
			ACT_ESC: begin
				esc_n = 1'b1;
			end
			ACT_BYTE: begin
				esc_n   = 1'b0;
				count_n = count_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Result.
	always_comb begin
		res_valid        = 1'b0;
		res.kind         = 1'b0;
		res.data_byte    = '0;
		res.byte_index   = '0;
		res.frame_length = '0;
		res.frame_ok     = 1'b0;
		unique case (act)
			ACT_END: begin
				res_valid        = 1'b1;
				res.kind         = 1'b1;
				res.frame_length = count_x[LENGTH_W-1:0];
				res.frame_ok     = (count_x >= XW'(min_len));
			end
			ACT_BYTE: begin
				res_valid      = 1'b1;
				res.data_byte  = dec_byte;
				res.byte_index = count_x[INDEX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framing_q <= 1'b0;
			esc_q     <= 1'b0;
			cmd_q     <= CMD_UNSEEN;
			count_q   <= '0;
		end else if (step) begin
			framing_q <= framing_n;
			esc_q     <= esc_n;
			cmd_q     <= cmd_n;
			count_q   <= count_n;
		end
	end

endmodule

FILE: hw/rtl/kiss_frame_deframer.sv
// KISS deframer top: input register, per-byte decoder, output register.
// Each byte goes from the input register through the decoder into the output register.
// Throughput: one byte per cycle while the result side takes beats; the input register
// and the output register each hold one beat, so one byte can wait behind a stalled result.
// Reset (arst_n low, asynchronous): no frame open, escape cleared, count zero,
// min_frame_len back to 20, both registers empty.
module kiss_frame_deframer #(
	parameter int unsigned MAX_PAYLOAD_BYTES = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [7:0] serial_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [31:0]                   m_axis_tdata,  // [7:0] data_byte,
	                                                     // [18:8] byte_index,
	                                                     // [30:19] frame_length,
	                                                     // [31] frame_ok
	output logic                          m_axis_tuser,  // [0] kind
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kfd_pkg::MIN_LEN_W-1:0] cfg_data      // min_frame_len
);
	import kfd_pkg::*;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 advance;
	logic                 res_valid;
	result_t              res;
	logic                 out_valid_q;
	result_t              out_q;
	logic [MIN_LEN_W-1:0] min_len_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
		end else if (cfg_valid) begin
			min_len_q <= cfg_data;
		end
	end

	// Input register: take a beat whenever the stage empties.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	kfd_decode #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.min_len   (min_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {out_q.frame_ok, out_q.frame_length, out_q.byte_index,
	                        out_q.data_byte};

endmodule

FILE: hw/rtl/kfd_checker.sv
// Port-level checks for the KISS deframer, bound to the top level.
// Depends on kiss_frame_deframer_macros.svh.
`include "kiss_frame_deframer_macros.svh"

module kfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	`KFD_ASSERT_ALWAYS(a_no_beat_in_reset, !arst_n |-> !m_axis_tvalid, "result beat during reset")
	`KFD_ASSERT(a_hold_stalled, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
	`KFD_ASSERT(a_byte_fields, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:19] == 13'd0, "byte beat carries frame-end fields")
	`KFD_ASSERT(a_end_fields, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[18:0] == 19'd0, "frame-end beat carries byte fields")

endmodule

bind kiss_frame_deframer kfd_checker u_kfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
